FILE: src/pso_pkg.sv
`default_nettype none
package pso_pkg;

  localparam int DIMS  = 16;
  localparam int DIM_W = (DIMS > 1) ? $clog2(DIMS) : 1;

  localparam logic [2:0] OP_LOAD_PV  = 3'd0;
  localparam logic [2:0] OP_POS_LIM  = 3'd1;
  localparam logic [2:0] OP_VEL_LIM  = 3'd2;
  localparam logic [2:0] OP_GBEST    = 3'd3;
  localparam logic [2:0] OP_INIT_PB  = 3'd4;
  localparam logic [2:0] OP_UPD_PB   = 3'd5;
  localparam logic [2:0] OP_STEP     = 3'd6;
  localparam logic [2:0] OP_UNUSED   = 3'd7;

  localparam logic [1:0] REG_INERTIA  = 2'd0;
  localparam logic [1:0] REG_PERSONAL = 2'd1;
  localparam logic [1:0] REG_GLOBAL   = 2'd2;

  localparam logic [15:0] INERTIA_RST  = 16'd2867;
  localparam logic [15:0] PERSONAL_RST = 16'd6144;
  localparam logic [15:0] GLOBAL_RST   = 16'd6144;

  localparam int PROD_W = 50;
  localparam int ACC_W  = 52;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY,
    S_EMIT,
    S_MUL,
    S_VEL,
    S_POS
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic first;
  } mac_ctl_t;

endpackage
`default_nettype wire

FILE: src/pso_mac.sv
`default_nettype none
module pso_mac import pso_pkg::*; (
  input  wire logic                    clk,
  input  wire mac_ctl_t                ctl,
  input  wire logic signed [32:0]      mul_a,
  input  wire logic signed [16:0]      mul_b,
  output logic signed [ACC_W-1:0]      acc
);

  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (ctl.acc_en) begin
      acc <= (ctl.first ? '0 : acc) + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

endmodule
`default_nettype wire

FILE: src/pso_particle_update.sv
// ops 0 to 3: result registered in the cycle after the transfer
// ops 4 and 5: a copy state walks all dimensions, then an emit state gives one result
// op 6: per dimension, three products and a final add on the shared
// multiply-accumulate unit, then velocity then position, one result each
// one item at a time; rst (synchronous) clears control, gains and best fitness
// coordinate and limit tables hold no reset value
`default_nettype none
module pso_particle_update import pso_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         op,
  input  wire logic [3:0]         dim_index,
  input  wire logic signed [31:0] value_a,
  input  wire logic signed [31:0] value_b,
  input  wire logic signed [31:0] fitness,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [3:0]              dim_out,
  output logic signed [31:0]      position_out,
  output logic signed [31:0]      velocity_out,
  output logic                    best_taken,
  output logic                    last
);

  logic [15:0] inertia_weight;
  logic [15:0] personal_gain;
  logic [15:0] global_gain;

  logic signed [31:0] pos_tab  [DIMS];
  logic signed [31:0] vel_tab  [DIMS];
  logic signed [31:0] pb_tab   [DIMS];
  logic signed [31:0] gb_tab   [DIMS];
  logic signed [31:0] pmax_tab [DIMS];
  logic signed [31:0] pmin_tab [DIMS];
  logic signed [31:0] vmax_tab [DIMS];
  logic signed [31:0] vmin_tab [DIMS];
  logic signed [31:0] best_fitness;

  state_t state, state_next;
  logic [DIM_W-1:0] dim_cnt;
  logic [1:0] phase;
  logic take;
  logic signed [31:0] vel_r;

  logic can_load;
  logic in_xfer;
  logic in_range;
  logic [DIM_W-1:0] idx_in;
  logic cnt_last;
  mac_ctl_t mac_ctl;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [ACC_W-1:0] acc;
  logic signed [39:0] vsh;
  logic signed [31:0] vsat;
  logic signed [31:0] vclamp;
  logic signed [31:0] x_cur;
  logic signed [32:0] psum;
  logic signed [31:0] psat;
  logic signed [31:0] pclamp;
  logic cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign can_load = !out_valid || !out_stall;
  assign in_stall = !(state == S_IDLE && can_load);
  assign in_xfer  = in_valid && !in_stall;
  assign idx_in   = DIM_W'(dim_index);
  assign in_range = 32'(dim_index) < DIMS;
  assign cnt_last = 32'(dim_cnt) == DIMS - 1;
  assign x_cur    = pos_tab[dim_cnt];

  always_ff @(posedge clk) begin
    if (rst) begin
      inertia_weight <= INERTIA_RST;
      personal_gain  <= PERSONAL_RST;
      global_gain    <= GLOBAL_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_INERTIA:  inertia_weight <= pwdata[15:0];
        REG_PERSONAL: personal_gain  <= pwdata[15:0];
        REG_GLOBAL:   global_gain    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_INERTIA:  prdata = {16'd0, inertia_weight};
      REG_PERSONAL: prdata = {16'd0, personal_gain};
      REG_GLOBAL:   prdata = {16'd0, global_gain};
      default:      prdata = '0;
    endcase
  end

  pso_mac u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .acc   (acc)
  );

  // velocity: floor shift, saturate, max clamp then min clamp
  always_comb begin
    vsh = acc[ACC_W-1:12];
    if (vsh[39:31] == {9{vsh[39]}}) begin
      vsat = vsh[31:0];
    end else begin
      vsat = vsh[39] ? 32'sh80000000 : 32'sh7fffffff;
    end
    vclamp = vsat;
    if (vclamp > vmax_tab[dim_cnt]) vclamp = vmax_tab[dim_cnt];
    if (vclamp < vmin_tab[dim_cnt]) vclamp = vmin_tab[dim_cnt];
  end

  always_comb begin
    psum = {x_cur[31], x_cur} + {vel_r[31], vel_r};
    if (psum[32] == psum[31]) begin
      psat = psum[31:0];
    end else begin
      psat = psum[32] ? 32'sh80000000 : 32'sh7fffffff;
    end
    pclamp = psat;
    if (pclamp > pmax_tab[dim_cnt]) pclamp = pmax_tab[dim_cnt];
    if (pclamp < pmin_tab[dim_cnt]) pclamp = pmin_tab[dim_cnt];
  end

  always_comb begin
    state_next = state;
    mac_ctl    = '0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (op == OP_INIT_PB || op == OP_UPD_PB) begin
            state_next = S_COPY;
          end else if (op == OP_STEP) begin
            state_next = S_MUL;
          end
        end
      end
      S_COPY: begin
        if (cnt_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (can_load) state_next = S_IDLE;
      end
      S_MUL: begin
        case (phase)
          2'd0: begin
            mac_ctl.mul_en = 1'b1;
            mul_a = {vel_tab[dim_cnt][31], vel_tab[dim_cnt]};
            mul_b = {1'b0, inertia_weight};
          end
          2'd1: begin
            mac_ctl = '{mul_en: 1'b1, acc_en: 1'b1, first: 1'b1};
            mul_a = {pb_tab[dim_cnt][31], pb_tab[dim_cnt]} - {x_cur[31], x_cur};
            mul_b = {1'b0, personal_gain};
          end
          2'd2: begin
            mac_ctl = '{mul_en: 1'b1, acc_en: 1'b1, first: 1'b0};
            mul_a = {gb_tab[dim_cnt][31], gb_tab[dim_cnt]} - {x_cur[31], x_cur};
            mul_b = {1'b0, global_gain};
          end
          default: begin
            mac_ctl.acc_en = 1'b1;
            state_next = S_VEL;
          end
        endcase
      end
      S_VEL: begin
        state_next = S_POS;
      end
      S_POS: begin
        if (can_load) state_next = cnt_last ? S_IDLE : S_MUL;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_cnt      <= '0;
      phase        <= '0;
      best_fitness <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          dim_cnt <= '0;
          phase   <= '0;
          if (in_xfer) begin
            if (op <= OP_GBEST && in_range) begin
              out_valid <= 1'b1;
            end
            if (op == OP_INIT_PB || (op == OP_UPD_PB && fitness <= best_fitness)) begin
              best_fitness <= fitness;
            end
          end
        end
        S_COPY: begin
          dim_cnt <= dim_cnt + 1'b1;
        end
        S_EMIT: begin
          if (can_load) out_valid <= 1'b1;
        end
        S_MUL: begin
          phase <= phase + 1'b1;
        end
        S_POS: begin
          if (can_load) begin
            out_valid <= 1'b1;
            dim_cnt   <= dim_cnt + 1'b1;
            phase     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // tables and result payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          take <= (op == OP_INIT_PB) || (fitness <= best_fitness);
          dim_out    <= dim_index;
          best_taken <= 1'b0;
          last       <= 1'b1;
          if (in_range) begin
            case (op)
              OP_LOAD_PV: begin
                pos_tab[idx_in] <= value_a;
                vel_tab[idx_in] <= value_b;
              end
              OP_POS_LIM: begin
                pmax_tab[idx_in] <= value_a;
                pmin_tab[idx_in] <= value_b;
              end
              OP_VEL_LIM: begin
                vmax_tab[idx_in] <= value_a;
                vmin_tab[idx_in] <= value_b;
              end
              OP_GBEST: gb_tab[idx_in] <= value_a;
              default: ;
            endcase
          end
          if (op == OP_LOAD_PV) begin
            position_out <= value_a;
            velocity_out <= value_b;
          end else begin
            position_out <= pos_tab[idx_in];
            velocity_out <= vel_tab[idx_in];
          end
        end
      end
      S_COPY: begin
        if (take) pb_tab[dim_cnt] <= pos_tab[dim_cnt];
      end
      S_EMIT: begin
        if (can_load) begin
          dim_out      <= '0;
          position_out <= '0;
          velocity_out <= '0;
          best_taken   <= take;
          last         <= 1'b1;
        end
      end
      S_VEL: begin
        vel_r <= vclamp;
      end
      S_POS: begin
        if (can_load) begin
          pos_tab[dim_cnt] <= pclamp;
          vel_tab[dim_cnt] <= vel_r;
          dim_out      <= 4'(dim_cnt);
          position_out <= pclamp;
          velocity_out <= vel_r;
          best_taken   <= 1'b0;
          last         <= cnt_last;
        end
      end
      default: ;
    endcase
  end

  a_copy_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY && cnt_last) |=> state == S_EMIT)
    else $error("pbest copy did not end in emit");

  a_mac_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && phase == 2'd3) |=> state == S_VEL)
    else $error("accumulate did not hand over to velocity");

  a_load_result: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && op <= OP_GBEST && in_range) |=> (out_valid && last))
    else $error("load transfer gave no result");

  a_step_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_POS && can_load && cnt_last) |=> (out_valid && last && state == S_IDLE))
    else $error("step did not close with last");

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import pso_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] op = '0;
  logic [3:0] dim_index = '0;
  logic signed [31:0] value_a = '0, value_b = '0, fitness = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] dim_out;
  logic signed [31:0] position_out, velocity_out;
  logic best_taken, last;

  pso_particle_update u_top (.*);

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] dim;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] fit;
  } cmd_t;

  typedef struct packed {
    logic [3:0] dim;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic taken;
    logic last;
  } res_t;

  cmd_t pending_cmds[$];
  res_t expected_res[$];
  int errors = 0;
  int gap_pct = 9;
  bit inputs_done = 0;

  // particle state mirror
  logic signed [31:0] pos_t[DIMS], vel_t[DIMS], pb_t[DIMS], gb_t[DIMS];
  logic signed [31:0] pmax_t[DIMS], pmin_t[DIMS], vmax_t[DIMS], vmin_t[DIMS];
  logic signed [31:0] best_fit;
  logic [15:0] w_g, c1_g, c2_g;

  initial forever #5 clk = ~clk;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] s);
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] clamp(input logic signed [31:0] v,
      input logic signed [31:0] hi, input logic signed [31:0] lo);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  task automatic predict_particle(input cmd_t c);
    logic signed [63:0] x, s, v64;
    logic signed [31:0] v, p;
    res_t r;
    if (c.op <= OP_GBEST) begin
      if (c.dim >= DIMS) return;
      case (c.op)
        OP_LOAD_PV: begin pos_t[c.dim] = c.a; vel_t[c.dim] = c.b; end
        OP_POS_LIM: begin pmax_t[c.dim] = c.a; pmin_t[c.dim] = c.b; end
        OP_VEL_LIM: begin vmax_t[c.dim] = c.a; vmin_t[c.dim] = c.b; end
        default: gb_t[c.dim] = c.a;
      endcase
      r = '{c.dim, pos_t[c.dim], vel_t[c.dim], 1'b0, 1'b1};
      expected_res.push_back(r);
    end else if (c.op == OP_INIT_PB || c.op == OP_UPD_PB) begin
      r = '{4'd0, 32'sd0, 32'sd0, 1'b0, 1'b1};
      if (c.op == OP_INIT_PB || c.fit <= best_fit) begin
        for (int i = 0; i < DIMS; i++) pb_t[i] = pos_t[i];
        best_fit = c.fit;
        r.taken = 1'b1;
      end
      expected_res.push_back(r);
    end else if (c.op == OP_STEP) begin
      for (int i = 0; i < DIMS; i++) begin
        x = pos_t[i];
        s = 64'(vel_t[i]) * $signed({48'd0, w_g})
          + (64'(pb_t[i]) - x) * $signed({48'd0, c1_g})
          + (64'(gb_t[i]) - x) * $signed({48'd0, c2_g});
        v64 = s >>> 12;
        v = clamp(sat32(v64), vmax_t[i], vmin_t[i]);
        p = clamp(sat32(x + 64'(v)), pmax_t[i], pmin_t[i]);
        vel_t[i] = v;
        pos_t[i] = p;
        r = '{4'(i), p, v, 1'b0, (i == DIMS - 1)};
        expected_res.push_back(r);
      end
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= gap_pct) begin
        cmd_t c;
        c = pending_cmds.pop_front();
        in_valid <= 1'b1;
        op <= c.op;
        dim_index <= c.dim;
        value_a <= c.a;
        value_b <= c.b;
        fitness <= c.fit;
        predict_particle(c);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_res.size() == 0) begin
          report("unexpected transfer", {60'd0, dim_out}, 64'd0);
        end else begin
          res_t e;
          e = expected_res.pop_front();
          if (dim_out !== e.dim) report("dim_out", dim_out, e.dim);
          if (position_out !== e.pos) report("position_out", position_out, e.pos);
          if (velocity_out !== e.vel) report("velocity_out", velocity_out, e.vel);
          if (best_taken !== e.taken) report("best_taken", best_taken, e.taken);
          if (last !== e.last) report("last", last, e.last);
        end
      end
      out_stall <= ($urandom_range(99) < gap_pct);
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_INERTIA: w_g = val;
      REG_PERSONAL: c1_g = val;
      default: c2_g = val;
    endcase
  endtask

  task automatic set_gains(input logic [15:0] w, input logic [15:0] c1, input logic [15:0] c2);
    apb_write(REG_INERTIA, w);
    apb_write(REG_PERSONAL, c1);
    apb_write(REG_GLOBAL, c2);
  endtask

  task automatic drain;
    while (pending_cmds.size() > 0 || expected_res.size() > 0 || in_valid) @(posedge clk);
    repeat (8 * DIMS) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd32;
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(131072)) - 32'sd65536;
      default: return $urandom;
    endcase
  endfunction

  task automatic add(input logic [2:0] o, input logic [3:0] d, input logic signed [31:0] a,
      input logic signed [31:0] b, input logic signed [31:0] f);
    pending_cmds.push_back('{o, d, a, b, f});
  endtask

  // writes every table entry so no read hits an unwritten one
  task automatic init_tables(input bit wide);
    for (int i = 0; i < DIMS; i++) begin
      if (wide) begin
        add(OP_POS_LIM, 4'(i), 32'sh7fffffff, 32'sh80000000, rnd32());
        add(OP_VEL_LIM, 4'(i), 32'sh7fffffff, 32'sh80000000, rnd32());
      end else begin
        add(OP_POS_LIM, 4'(i), rnd32(), rnd32(), rnd32());
        add(OP_VEL_LIM, 4'(i), rnd32(), rnd32(), rnd32());
      end
      add(OP_LOAD_PV, 4'(i), rnd32(), rnd32(), rnd32());
      add(OP_GBEST, 4'(i), rnd32(), rnd32(), rnd32());
    end
    add(OP_INIT_PB, 4'($urandom), rnd32(), rnd32(), rnd32());
  endtask

  initial begin
    w_g = INERTIA_RST; c1_g = PERSONAL_RST; c2_g = GLOBAL_RST;
    best_fit = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset gains, full-range limits, extremes
    init_tables(1);
    add(OP_LOAD_PV, 4'd0, 32'sh7fffffff, 32'sh7fffffff, 0);
    add(OP_LOAD_PV, 4'd15, 32'sh80000000, 32'sh80000000, 0);
    add(OP_STEP, 4'd0, 0, 0, 0);
    add(OP_UPD_PB, 4'd0, 0, 0, 0);
    add(OP_UPD_PB, 4'd0, 0, 0, 32'sh7fffffff);
    add(OP_UPD_PB, 4'd0, 0, 0, 32'sh80000000);
    add(OP_POS_LIM, 4'd3, -32'sd65536, 32'sd65536, 0);
    add(OP_VEL_LIM, 4'd4, -32'sd65536, 32'sd65536, 0);
    add(OP_UNUSED, 4'd5, 0, 0, 0);
    add(OP_STEP, 4'd0, 0, 0, 0);
    drain();

    set_gains(16'hffff, 16'hffff, 16'hffff);
    add(OP_STEP, 4'd0, 0, 0, 0);
    add(OP_STEP, 4'd0, 0, 0, 0);
    drain();
    set_gains(16'd0, 16'd0, 16'd0);
    add(OP_STEP, 4'd0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 2; ph++) begin
      gap_pct = (ph == 1) ? 0 : 9;
      set_gains($urandom, $urandom, $urandom);
      init_tables(ph[0]);
      for (int n = 0; n < 40; n++) begin
        case ($urandom_range(9))
          0, 1, 2: add(OP_STEP, 4'($urandom), rnd32(), rnd32(), rnd32());
          3: add(OP_UPD_PB, 4'($urandom), rnd32(), rnd32(), rnd32());
          4: add(OP_INIT_PB, 4'($urandom), rnd32(), rnd32(), rnd32());
          9: add(OP_UNUSED, 4'($urandom), rnd32(), rnd32(), rnd32());
          default: add(3'($urandom_range(3)), 4'($urandom), rnd32(), rnd32(), rnd32());
        endcase
      end
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
